// File: hdl/rau_pkg.sv
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
  localparam int WIDE          = 64;
  localparam int CNT_W         = $clog2(WIDE + 1);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_DIFF = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_RED  = 3'd4;

  // Control between sequencer and divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: fraction ops with Euclid gcd reduction.
// Throughput: one beat at a time; in_ready only while the sequencer is idle.
// Reset: synchronous active-high rst returns the sequencer to idle, no result pending.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     req_type,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic [DEN_WIDTH-1:0]           a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic [DEN_WIDTH-1:0]           b_den,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [63:0]             first_num,
  output logic signed [63:0]             first_den,
  output logic signed [31:0]             second_num,
  output logic signed [31:0]             second_den,
  output logic                           error
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_BUILD, S_GCD, S_GWAIT,
    S_DIVN, S_WN, S_DIVD, S_WD, S_NEXT, S_OUT
  } state_t;

  state_t state;
  logic [2:0] op;
  logic signed [WIDE-1:0] an, ad, bn, bd;
  logic signed [WIDE-1:0] p1, p2;
  logic signed [WIDE-1:0] n, d, x, y, g;
  logic signed [WIDE-1:0] n2s, d2s;
  logic second;
  logic ok;

  // shared multiplier operands
  logic signed [WIDE-1:0] ma, mb, mprod;
  div_ctl_t dctl;
  div_sts_t dsts;
  logic signed [WIDE-1:0] dnd, dsr, dq, dr;

  always_comb begin
    ma = an; mb = bd;
    case (state)
      S_MUL1:  begin ma = an; mb = (op == OP_MUL) ? bn : bd; end
      S_MUL2:  begin ma = bn; mb = ad; end
      S_BUILD: begin ma = ad; mb = (op == OP_DIV) ? bn : bd; end
      default: ;
    endcase
    mprod = WIDE'($signed(ma[31:0]) * $signed(mb[31:0]));
  end

  rau_divider u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(dnd), .divisor(dsr),
    .sts(dsts), .quot(dq), .rem(dr)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    logic start_next;
    start_next = 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          op <= req_type;
          an <= WIDE'(a_num); ad <= WIDE'({1'b0, a_den});
          bn <= WIDE'(b_num); bd <= WIDE'({1'b0, b_den});
          second <= 1'b0; ok <= 1'b1;
          state <= S_MUL1;
        end
        S_MUL1: begin p1 <= mprod; state <= S_MUL2; end
        S_MUL2: begin p2 <= mprod; state <= S_BUILD; end
        S_BUILD: begin
          case (op)
            OP_ADD:  begin n <= p1 + p2; d <= mprod; end
            OP_DIFF: begin n <= (p1 > p2) ? p1 - p2 : p2 - p1; d <= mprod; end
            OP_MUL, OP_DIV: begin n <= p1; d <= mprod; end
            OP_RED:  begin n <= an; d <= ad; end
            default: ;
          endcase
          state <= (op > OP_RED) ? S_OUT : S_GCD;
          if (op > OP_RED) begin n <= '0; d <= '0; n2s <= '0; d2s <= '0; end
        end
        // first divide of the gcd chain is loaded from n/d
        S_GCD: begin
          x <= n; y <= d;
          state <= S_GWAIT;
          if (d != 0 && d != -64'sd1) begin
            dnd <= n; dsr <= d; start_next = 1'b1;
          end
        end
        S_GWAIT: begin
          if (y == 0) begin
            g <= x;
            state <= S_DIVN;
          end else if (y == -64'sd1) begin
            x <= y; y <= '0;
          end else if (dsts.done) begin
            x <= y; y <= dr;
            if (dr != 0 && dr != -64'sd1) begin
              dnd <= y; dsr <= dr; start_next = 1'b1;
            end
          end
        end
        S_DIVN: begin
          if (g == 0) begin ok <= 1'b0; state <= S_NEXT; end
          else begin dnd <= n; dsr <= g; start_next = 1'b1; state <= S_WN; end
        end
        S_WN: if (dsts.done) begin
          n <= dq; dnd <= d; dsr <= g; start_next = 1'b1; state <= S_WD;
        end
        S_WD: if (dsts.done) begin d <= dq; state <= S_NEXT; end
        S_NEXT: begin
          if (op == OP_RED && !second) begin
            second <= 1'b1;
            p1 <= n; p2 <= d;
            n <= bn; d <= bd;
            state <= S_GCD;
          end else begin
            if (op == OP_RED) begin
              n2s <= n; d2s <= d; n <= p1; d <= p2;
            end else begin
              n2s <= '0; d2s <= '0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= !(out_valid && out_ready);
          first_num <= ok ? n : '0;
          first_den <= ok ? d : '0;
          second_num <= ok ? n2s[31:0] : '0;
          second_den <= ok ? d2s[31:0] : '0;
          error <= ~ok;
          if (out_valid && out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    dctl.start <= start_next;
  end

endmodule

// File: hdl/rau_divider.sv
// Signed truncating divider, one quotient bit per cycle (restoring).
module rau_divider import rau_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  div_ctl_t               ctl,
  input  logic signed [WIDE-1:0] dividend,
  input  logic signed [WIDE-1:0] divisor,
  output div_sts_t               sts,
  output logic signed [WIDE-1:0] quot,
  output logic signed [WIDE-1:0] rem
);

  logic [WIDE-1:0]  q;
  logic [WIDE:0]    r;
  logic [WIDE-1:0]  dv;
  logic [CNT_W-1:0] cnt;
  logic             neg_q;
  logic             neg_r;
  logic             busy;
  logic             done;
  logic [WIDE:0]    r_sh;
  logic [WIDE:0]    r_sub;

  // One restoring step
  always_comb begin
    r_sh  = {r[WIDE-1:0], q[WIDE-1]};
    r_sub = r_sh - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    // done pulses for one cycle after the last step
    done <= !rst && !ctl.start && busy && (cnt == CNT_W'(1));
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      cnt   <= CNT_W'(WIDE);
      r     <= '0;
      q     <= dividend[WIDE-1] ? WIDE'(-dividend) : dividend;
      dv    <= divisor[WIDE-1] ? WIDE'(-divisor) : divisor;
      neg_q <= dividend[WIDE-1] ^ divisor[WIDE-1];
      neg_r <= dividend[WIDE-1];
    end else if (busy) begin
      if (!r_sub[WIDE]) begin
        r <= r_sub;
        q <= {q[WIDE-2:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[WIDE-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot     = neg_q ? WIDE'(-q) : q;
  assign rem      = neg_r ? WIDE'(-r[WIDE-1:0]) : r[WIDE-1:0];
  assign sts.busy = busy;
  assign sts.done = done;

endmodule
